// ----- hdl/assert_macros.svh -----
// Assertion macros used by the RTL. Each clocks on clk and is off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define SWF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge out of reset.
`define SWF_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hdl/swf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swf_pkg
// Constants, pipeline types and saturation helpers of the shallow-water
// flux cell update.
// ----------------------------------------------------------------------------
package swf_pkg;

    localparam int FRAC_BITS = 20;
    localparam int DATA_W    = 32;
    localparam int GUARD_W   = 33;
    localparam int REG_W     = 31;
    localparam int DIV_STEPS = 32;
    // s1, s2, divider entry plus one stage per quotient bit, four tail stages, output
    localparam int NSTG      = DIV_STEPS + 8;
    localparam int DIV_NUM   = 4;

    localparam logic [REG_W-1:0] HALF_GRAV_RST = REG_W'(5 << FRAC_BITS);
    localparam logic [REG_W-1:0] COURANT_RST   = REG_W'((1 << FRAC_BITS) / 40);

    localparam logic signed [GUARD_W-1:0] GUARD_HI = {1'b0, {(GUARD_W-1){1'b1}}};
    localparam logic signed [GUARD_W-1:0] GUARD_LO = {1'b1, {(GUARD_W-1){1'b0}}};

    typedef enum logic [0:0] {
        REG_HALF_GRAVITY = 1'b0,
        REG_COURANT      = 1'b1
    } reg_idx_t;

    // divider lanes: cross products and squared terms of both neighbors
    localparam int DV_CROSS_L = 0;
    localparam int DV_CROSS_U = 1;
    localparam int DV_SQ_L    = 2;
    localparam int DV_SQ_U    = 3;

    typedef struct packed {
        logic [DATA_W-1:0]  rem;
        logic [DATA_W-1:0]  num;
        logic [DATA_W-1:0]  quot;
        logic [REG_W-1:0]   den;
        logic               neg;
        logic               ovf;
        logic               zero;
    } div_t;

    typedef struct packed {
        logic                       op;
        logic                       fault;
        logic signed [DATA_W-1:0]   mean_h;
        logic signed [DATA_W-1:0]   mean_x;
        logic signed [DATA_W-1:0]   mean_y;
        logic signed [GUARD_W-1:0]  ddiff;
        logic [2*DATA_W-2:0]        gp_l;
        logic [2*DATA_W-2:0]        gp_u;
    } side_t;

    function automatic logic signed [GUARD_W-1:0] sat_guard(
        input logic signed [GUARD_W:0] x
    );
        logic signed [GUARD_W-1:0] r;
        if (x[GUARD_W] != x[GUARD_W-1])
            r = x[GUARD_W] ? GUARD_LO : GUARD_HI;
        else
            r = x[GUARD_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_out(
        input logic signed [2*DATA_W:0] x
    );
        logic signed [DATA_W-1:0] r;
        if ((&x[2*DATA_W:DATA_W-1]) || !(|x[2*DATA_W:DATA_W-1]))
            r = x[DATA_W-1:0];
        else
            r = x[2*DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/shallow_water_flux_cell_update_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// An accepted item passes the input and product stages, the divider and the tail stages to the output.
// Throughput: one item per cycle; the whole pipeline holds while a valid result at the output is stalled.
// The divider retires one quotient bit per stage, which sets the depth.
// Reset: asynchronous, active low; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// shallow_water_flux_cell_update_unit
// Lax-Friedrichs update of one grid cell from its two neighbors along x or y.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shallow_water_flux_cell_update_unit
    import swf_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [0:0]                 cfg_index,
    input  wire logic [REG_W-1:0]           cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       operation,
    input  wire logic signed [DATA_W-1:0]   lower_depth,
    input  wire logic signed [DATA_W-1:0]   lower_mom_x,
    input  wire logic signed [DATA_W-1:0]   lower_mom_y,
    input  wire logic signed [DATA_W-1:0]   upper_depth,
    input  wire logic signed [DATA_W-1:0]   upper_mom_x,
    input  wire logic signed [DATA_W-1:0]   upper_mom_y,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [DATA_W-1:0]        new_depth,
    output logic signed [DATA_W-1:0]        new_mom_x,
    output logic signed [DATA_W-1:0]        new_mom_y,
    output logic                            depth_fault
);

    logic [REG_W-1:0] hg_reg, cf_reg;
    logic [NSTG-1:0]  vld_reg, vld_next;
    logic             adv;

    // stage 1: inputs
    logic                     op1_reg;
    logic signed [DATA_W-1:0] lh1_reg, lu1_reg, lv1_reg, uh1_reg, uu1_reg, uv1_reg;

    // stage 2: products
    logic signed [2*DATA_W-1:0] prod2_reg [DIV_NUM];
    logic signed [2*DATA_W-1:0] hhl2_reg, hhu2_reg;
    logic signed [DATA_W-1:0]   lh2_reg, uh2_reg;
    logic signed [DATA_W-1:0]   mh2_reg, mx2_reg, my2_reg;
    logic signed [GUARD_W-1:0]  dd2_reg;
    logic                       op2_reg, flt2_reg;

    // divider chain, entry 0 is the prepared operand
    div_t  dv_reg   [DIV_STEPS+1][DIV_NUM];
    div_t  dv_next  [DIV_STEPS+1][DIV_NUM];
    side_t sd_reg   [DIV_STEPS+1];
    side_t sd0_next;

    // tail stages
    logic signed [GUARD_W-1:0] r_reg [DIV_NUM];
    logic signed [GUARD_W-1:0] pl_reg, pu_reg;
    logic signed [GUARD_W-1:0] fl_reg, fu_reg, cl_reg, cu_reg;
    logic signed [GUARD_W-1:0] dh_reg, dx_reg, dy_reg;
    logic signed [2*DATA_W-1:0] ch_reg, cx_reg, cy_reg;
    side_t sf1_reg, sf2_reg, sf3_reg, sf4_reg;
    logic signed [DATA_W-1:0] oh_reg, ox_reg, oy_reg;
    logic                     of_reg;

    assign adv       = !vld_reg[NSTG-1] || !out_stall;
    assign in_stall  = !adv;
    assign out_valid = vld_reg[NSTG-1];
    assign new_depth = oh_reg;
    assign new_mom_x = ox_reg;
    assign new_mom_y = oy_reg;
    assign depth_fault = of_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hg_reg <= HALF_GRAV_RST;
            cf_reg <= COURANT_RST;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_HALF_GRAVITY: hg_reg <= cfg_data;
                REG_COURANT:      cf_reg <= cfg_data;
                default:          hg_reg <= hg_reg;
            endcase
        end
    end

    assign vld_next = {vld_reg[NSTG-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // stage 1 and 2
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg <= operation;
            lh1_reg <= lower_depth;
            lu1_reg <= lower_mom_x;
            lv1_reg <= lower_mom_y;
            uh1_reg <= upper_depth;
            uu1_reg <= upper_mom_x;
            uv1_reg <= upper_mom_y;

            prod2_reg[DV_CROSS_L] <= lu1_reg * lv1_reg;
            prod2_reg[DV_CROSS_U] <= uu1_reg * uv1_reg;
            prod2_reg[DV_SQ_L]    <= op1_reg ? lv1_reg * lv1_reg : lu1_reg * lu1_reg;
            prod2_reg[DV_SQ_U]    <= op1_reg ? uv1_reg * uv1_reg : uu1_reg * uu1_reg;
            hhl2_reg <= lh1_reg * lh1_reg;
            hhu2_reg <= uh1_reg * uh1_reg;
            lh2_reg  <= lh1_reg;
            uh2_reg  <= uh1_reg;
            mh2_reg  <= DATA_W'((GUARD_W'(lh1_reg) + GUARD_W'(uh1_reg)) >>> 1);
            mx2_reg  <= DATA_W'((GUARD_W'(lu1_reg) + GUARD_W'(uu1_reg)) >>> 1);
            my2_reg  <= DATA_W'((GUARD_W'(lv1_reg) + GUARD_W'(uv1_reg)) >>> 1);
            dd2_reg  <= op1_reg ? GUARD_W'(uv1_reg) - GUARD_W'(lv1_reg)
                                : GUARD_W'(uu1_reg) - GUARD_W'(lu1_reg);
            op2_reg  <= op1_reg;
            flt2_reg <= (lh1_reg <= 0) || (uh1_reg <= 0);
        end
    end

    // divider entry: magnitude, overflow check, pressure product
    always_comb
    begin
        logic signed [2*DATA_W-1:0] p;
        logic [2*DATA_W-1:0]        mag;
        logic signed [DATA_W-1:0]   h;
        logic [2*DATA_W-1:0]        hsl, hsu;
        logic [DATA_W-1:0]          h2l, h2u;
        logic [DATA_W-1:0]          t;
        logic                       ge;
        for (int k = 0; k < DIV_NUM; k++)
        begin
            p   = prod2_reg[k];
            h   = (k == DV_CROSS_L || k == DV_SQ_L) ? lh2_reg : uh2_reg;
            mag = p[2*DATA_W-1] ? (2*DATA_W)'(-p) : (2*DATA_W)'(p);
            dv_next[0][k].neg  = p[2*DATA_W-1];
            dv_next[0][k].zero = (h <= 0);
            dv_next[0][k].den  = h[REG_W-1:0];
            dv_next[0][k].ovf  = mag[2*DATA_W-2:DATA_W] >= h[REG_W-1:0];
            dv_next[0][k].rem  = {1'b0, mag[2*DATA_W-2:DATA_W]};
            dv_next[0][k].num  = mag[DATA_W-1:0];
            dv_next[0][k].quot = '0;
        end
        hsl = (2*DATA_W)'(hhl2_reg) >> FRAC_BITS;
        hsu = (2*DATA_W)'(hhu2_reg) >> FRAC_BITS;
        h2l = (|hsl[2*DATA_W-1:DATA_W]) ? '1 : hsl[DATA_W-1:0];
        h2u = (|hsu[2*DATA_W-1:DATA_W]) ? '1 : hsu[DATA_W-1:0];
        sd0_next.op     = op2_reg;
        sd0_next.fault  = flt2_reg;
        sd0_next.mean_h = mh2_reg;
        sd0_next.mean_x = mx2_reg;
        sd0_next.mean_y = my2_reg;
        sd0_next.ddiff  = dd2_reg;
        sd0_next.gp_l   = (2*DATA_W-1)'(hg_reg) * (2*DATA_W-1)'(h2l);
        sd0_next.gp_u   = (2*DATA_W-1)'(hg_reg) * (2*DATA_W-1)'(h2u);

        // one quotient bit per stage
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            for (int k = 0; k < DIV_NUM; k++)
            begin
                t  = {dv_reg[i][k].rem[DATA_W-2:0], dv_reg[i][k].num[DATA_W-1]};
                ge = t >= {1'b0, dv_reg[i][k].den};
                dv_next[i+1][k]      = dv_reg[i][k];
                dv_next[i+1][k].rem  = ge ? t - {1'b0, dv_reg[i][k].den} : t;
                dv_next[i+1][k].num  = {dv_reg[i][k].num[DATA_W-2:0], 1'b0};
                dv_next[i+1][k].quot = {dv_reg[i][k].quot[DATA_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
                dv_reg[i] <= dv_next[i];
            sd_reg[0] <= sd0_next;
            for (int i = 0; i < DIV_STEPS; i++)
                sd_reg[i+1] <= sd_reg[i];
        end
    end

    // tail: ratios and pressure, fluxes, differences, correction, result
    always_ff @(posedge clk)
    begin
        logic [2*DATA_W-2:0] psl, psu;
        if (adv)
        begin
            for (int k = 0; k < DIV_NUM; k++)
            begin
                if (dv_reg[DIV_STEPS][k].zero)
                    r_reg[k] <= '0;
                else if (dv_reg[DIV_STEPS][k].ovf)
                    r_reg[k] <= dv_reg[DIV_STEPS][k].neg ? GUARD_LO : GUARD_HI;
                else if (dv_reg[DIV_STEPS][k].neg)
                    r_reg[k] <= -$signed({1'b0, dv_reg[DIV_STEPS][k].quot});
                else
                    r_reg[k] <= $signed({1'b0, dv_reg[DIV_STEPS][k].quot});
            end
            psl = sd_reg[DIV_STEPS].gp_l >> FRAC_BITS;
            psu = sd_reg[DIV_STEPS].gp_u >> FRAC_BITS;
            pl_reg  <= {1'b0, (|psl[2*DATA_W-2:DATA_W]) ? {DATA_W{1'b1}} : psl[DATA_W-1:0]};
            pu_reg  <= {1'b0, (|psu[2*DATA_W-2:DATA_W]) ? {DATA_W{1'b1}} : psu[DATA_W-1:0]};
            sf1_reg <= sd_reg[DIV_STEPS];

            fl_reg  <= sat_guard((GUARD_W+1)'(r_reg[DV_SQ_L]) + (GUARD_W+1)'(pl_reg));
            fu_reg  <= sat_guard((GUARD_W+1)'(r_reg[DV_SQ_U]) + (GUARD_W+1)'(pu_reg));
            cl_reg  <= r_reg[DV_CROSS_L];
            cu_reg  <= r_reg[DV_CROSS_U];
            sf2_reg <= sf1_reg;

            dh_reg  <= sf2_reg.ddiff;
            dx_reg  <= sf2_reg.op ? sat_guard((GUARD_W+1)'(cu_reg) - (GUARD_W+1)'(cl_reg))
                                  : sat_guard((GUARD_W+1)'(fu_reg) - (GUARD_W+1)'(fl_reg));
            dy_reg  <= sf2_reg.op ? sat_guard((GUARD_W+1)'(fu_reg) - (GUARD_W+1)'(fl_reg))
                                  : sat_guard((GUARD_W+1)'(cu_reg) - (GUARD_W+1)'(cl_reg));
            sf3_reg <= sf2_reg;

            ch_reg  <= $signed({{(DATA_W+1){1'b0}}, cf_reg}) * (2*DATA_W)'(dh_reg);
            cx_reg  <= $signed({{(DATA_W+1){1'b0}}, cf_reg}) * (2*DATA_W)'(dx_reg);
            cy_reg  <= $signed({{(DATA_W+1){1'b0}}, cf_reg}) * (2*DATA_W)'(dy_reg);
            sf4_reg <= sf3_reg;

            oh_reg  <= sat_out((2*DATA_W+1)'(sf4_reg.mean_h) - (2*DATA_W+1)'(ch_reg >>> FRAC_BITS));
            ox_reg  <= sat_out((2*DATA_W+1)'(sf4_reg.mean_x) - (2*DATA_W+1)'(cx_reg >>> FRAC_BITS));
            oy_reg  <= sat_out((2*DATA_W+1)'(sf4_reg.mean_y) - (2*DATA_W+1)'(cy_reg >>> FRAC_BITS));
            of_reg  <= sf4_reg.fault;
        end
    end

    `SWF_ASSERT(a_hold_valid, !adv |=> $stable(vld_reg), "pipeline moved while output stalled")
    `SWF_ASSERT(a_rem_bound, vld_reg[DIV_STEPS+2] && !dv_reg[DIV_STEPS][0].zero && !dv_reg[DIV_STEPS][0].ovf |-> dv_reg[DIV_STEPS][0].rem < {1'b0, dv_reg[DIV_STEPS][0].den}, "divider remainder not below divisor")
    `SWF_ASSERT(a_out_rise, $rose(out_valid) |-> $past(adv), "result appeared without pipeline advance")

endmodule
`default_nettype wire

// ----- tb/sv/swf_update_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swf_update_checker
// Watches both channels of the cell update unit, predicts each updated cell
// from the accepted neighbors and the live register values, and compares.
// ----------------------------------------------------------------------------
module swf_update_checker
    import swf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [0:0]                 cfg_index,
    input  logic [REG_W-1:0]           cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       operation,
    input  logic signed [DATA_W-1:0]   lower_depth,
    input  logic signed [DATA_W-1:0]   lower_mom_x,
    input  logic signed [DATA_W-1:0]   lower_mom_y,
    input  logic signed [DATA_W-1:0]   upper_depth,
    input  logic signed [DATA_W-1:0]   upper_mom_x,
    input  logic signed [DATA_W-1:0]   upper_mom_y,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [DATA_W-1:0]   new_depth,
    input  logic signed [DATA_W-1:0]   new_mom_x,
    input  logic signed [DATA_W-1:0]   new_mom_y,
    input  logic                       depth_fault,
    output int                         fail_count,
    output int                         pending
);

    typedef struct packed {
        logic signed [DATA_W-1:0] h;
        logic signed [DATA_W-1:0] mx;
        logic signed [DATA_W-1:0] my;
        logic                     fault;
    } cell_t;

    localparam longint G_HI = 64'sd4294967295;
    localparam longint G_LO = -64'sd4294967296;
    localparam longint O_HI = 64'sd2147483647;
    localparam longint O_LO = -64'sd2147483648;

    cell_t cell_q[$];
    logic [REG_W-1:0] grav_r, cour_r;

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic longint quot_term(longint a, longint b, longint h);
        if (h <= 0)
            return 0;
        return clip((a * b) / h, G_LO, G_HI);
    endfunction

    function automatic longint press_term(longint h);
        longint h2;
        h2 = clip((h * h) >>> FRAC_BITS, 0, G_HI);
        return clip((longint'(grav_r) * h2) >>> FRAC_BITS, G_LO, G_HI);
    endfunction

    function automatic logic signed [DATA_W-1:0] lf_step(longint lo, longint up,
                                                       longint fl, longint fu);
        longint mean, d, corr;
        mean = (lo + up) >>> 1;
        d = clip(fu - fl, G_LO, G_HI);
        corr = (longint'(cour_r) * d) >>> FRAC_BITS;
        return DATA_W'(clip(mean - corr, O_LO, O_HI));
    endfunction

    function automatic cell_t predict_cell();
        cell_t c;
        longint lh, lu, lv, uh, uu, uv, xl, xu, fl, fu;
        lh = lower_depth; lu = lower_mom_x; lv = lower_mom_y;
        uh = upper_depth; uu = upper_mom_x; uv = upper_mom_y;
        xl = quot_term(lu, lv, lh);
        xu = quot_term(uu, uv, uh);
        if (!operation)
        begin
            fl = clip(quot_term(lu, lu, lh) + press_term(lh), G_LO, G_HI);
            fu = clip(quot_term(uu, uu, uh) + press_term(uh), G_LO, G_HI);
            c.h  = lf_step(lh, uh, lu, uu);
            c.mx = lf_step(lu, uu, fl, fu);
            c.my = lf_step(lv, uv, xl, xu);
        end
        else
        begin
            fl = clip(quot_term(lv, lv, lh) + press_term(lh), G_LO, G_HI);
            fu = clip(quot_term(uv, uv, uh) + press_term(uh), G_LO, G_HI);
            c.h  = lf_step(lh, uh, lv, uv);
            c.mx = lf_step(lu, uu, xl, xu);
            c.my = lf_step(lv, uv, fl, fu);
        end
        c.fault = (lh <= 0) || (uh <= 0);
        return c;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        cell_t want;
        if (!rst_n)
        begin
            grav_r <= HALF_GRAV_RST;
            cour_r <= COURANT_RST;
        end
        else
        begin
            if (in_valid && !in_stall)
                cell_q.push_back(predict_cell());
            if (out_valid && !out_stall)
            begin
                if (cell_q.size() == 0)
                    report("unexpected item", 0, 0);
                else
                begin
                    want = cell_q.pop_front();
                    if (new_depth !== want.h)
                        report("new_depth", new_depth, want.h);
                    if (new_mom_x !== want.mx)
                        report("new_mom_x", new_mom_x, want.mx);
                    if (new_mom_y !== want.my)
                        report("new_mom_y", new_mom_y, want.my);
                    if (depth_fault !== want.fault)
                        report("depth_fault", depth_fault, want.fault);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_HALF_GRAVITY)
                    grav_r <= cfg_data;
                else if (cfg_index == REG_COURANT)
                    cour_r <= cfg_data;
            end
        end
        pending = cell_q.size();
    end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives neighbor pairs into the cell update unit under bursty input and
// patterned output stalls, across several register settings; the checker
// does the prediction and the verdict comes from its failure count.
// ----------------------------------------------------------------------------
module tb_top;
    import swf_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_HALF_GRAVITY;
    logic [REG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic operation = 1'b0;
    logic signed [DATA_W-1:0] lower_depth = '0, lower_mom_x = '0, lower_mom_y = '0;
    logic signed [DATA_W-1:0] upper_depth = '0, upper_mom_x = '0, upper_mom_y = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [DATA_W-1:0] new_depth, new_mom_x, new_mom_y;
    logic depth_fault;
    int fail_count, pending;
    bit hold_off = 1'b0;
    bit hold_done = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    shallow_water_flux_cell_update_unit u_top (.*);
    swf_update_checker u_check (.*);

    // receiver: random pattern, with one long hold while the sender keeps going
    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
                hold_done = 1'b1;
                hold_off = 1'b0;
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                default: out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic logic signed [DATA_W-1:0] pick_value(bit depth_like);
        case ($urandom_range(0, 9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sd0;
            3: return $urandom;
            4: return -$signed(32'($urandom_range(0, 1 << 22)));
            default:
                return depth_like ? 32'($urandom_range(1 << 18, 1 << 24))
                                  : $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23);
        endcase
    endfunction

    task automatic send_cell(bit op, logic signed [DATA_W-1:0] lh, lu, lv,
                             logic signed [DATA_W-1:0] uh, uu, uv);
        in_valid    <= 1'b1;
        operation   <= op;
        lower_depth <= lh; lower_mom_x <= lu; lower_mom_y <= lv;
        upper_depth <= uh; upper_mom_x <= uu; upper_mom_y <= uv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic idle_cycles(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int burst;
        while (n > 0)
        begin
            burst = $urandom_range(1, 24);
            repeat (burst)
            begin
                send_cell(1'($urandom_range(0, 1)), pick_value(1), pick_value(0),
                          pick_value(0), pick_value(1), pick_value(0), pick_value(0));
                n--;
            end
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both sweeps, non-positive depths
        for (k = 0; k < 2; k++)
        begin
            send_cell(1'(k), 32'sh100000, 32'sh100000, 32'sh80000,
                      32'sh200000, -32'sh100000, 32'sh40000);
            send_cell(1'(k), 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
            send_cell(1'(k), 32'sh80000000, 32'sh80000000, 32'sh80000000,
                      32'sh80000000, 32'sh80000000, 32'sh80000000);
            send_cell(1'(k), 32'sd0, 32'sh500000, 32'sh300000,
                      32'sh100000, 32'sh200000, -32'sh200000);
            send_cell(1'(k), 32'sh100000, 32'sh7fffffff, 32'sh80000000,
                      -32'sd1, 32'sh80000000, 32'sh7fffffff);
            send_cell(1'(k), 32'sd1, 32'sh7fffffff, 32'sh7fffffff,
                      32'sd1, 32'sh80000000, 32'sh80000000);
            send_cell(1'(k), 32'sh7fffffff, 32'sd0, 32'sd0,
                      32'sd1, 32'sd0, 32'sd0);
            send_cell(1'(k), -32'sd1, -32'sd1, -32'sd1, 32'sd0, 32'sd0, 32'sd0);
        end
        drain();

        random_phase(250);
        // long hold-off on the output while the input keeps offering
        hold_off = 1'b1;
        random_phase(120);
        while (!hold_done)
            @(posedge clk);
        drain();

        write_reg(REG_HALF_GRAVITY, '1);
        write_reg(REG_COURANT, '1);
        random_phase(220);
        drain();
        write_reg(REG_HALF_GRAVITY, '0);
        write_reg(REG_COURANT, '0);
        random_phase(220);
        drain();
        write_reg(REG_HALF_GRAVITY, REG_W'($urandom));
        write_reg(REG_COURANT, REG_W'($urandom_range(0, 1 << 21)));
        random_phase(220);
        drain();
        write_reg(REG_HALF_GRAVITY, HALF_GRAV_RST);
        write_reg(REG_COURANT, COURANT_RST);
        random_phase(250);
        drain();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #(12 * 400000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/swf_pkg.sv
hdl/shallow_water_flux_cell_update_unit.sv
tb/sv/swf_update_checker.sv
tb/sv/tb_top.sv
